FILE: sv/wrr_pkg.sv
package wrr_pkg;

  // Angle and output formats.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ANG_IN_W   = 16;
  localparam int ANG_EXT_W  = 24;
  localparam int IDX_W      = 3;
  localparam int OUT_W      = FRAC_BITS + 2;
  localparam int OUT_SH     = 30 - FRAC_BITS;

  // Internal Q30 word, wide enough for 1 +- cos and the products of the reduced terms.
  localparam int Q30W = 34;
  typedef logic signed [Q30W-1:0] q30_t;

  localparam q30_t ONE_Q30  = q30_t'(64'd1 << 30);
  localparam q30_t SQ38_Q30 = q30_t'(64'd657529896);
  localparam logic [29:0] PI4_Q30 = 30'd843314857;

  // Taylor series: terms up to x^TERMS/TERMS!, three stages per term after the first.
  localparam int TERMS    = 13;
  localparam int TRIG_LAT = 3 * (TERMS - 1) + 3;

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Projection index codes, two's complement.
  localparam logic [IDX_W-1:0] IDX_M2 = 3'b110;
  localparam logic [IDX_W-1:0] IDX_M1 = 3'b111;
  localparam logic [IDX_W-1:0] IDX_Z  = 3'b000;
  localparam logic [IDX_W-1:0] IDX_P1 = 3'b001;
  localparam logic [IDX_W-1:0] IDX_P2 = 3'b010;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] beta;
    logic [ANGLE_BITS-1:0] phase;
    logic [IDX_W-1:0]      m;
    logic [IDX_W-1:0]      n;
    logic                  invalid;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Product of two Q30 values, truncated toward zero.
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic                neg;
    logic [Q30W-1:0]     ua;
    logic [Q30W-1:0]     ub;
    logic [2*Q30W-1:0]   pr;
    logic [Q30W-1:0]     pm;
    neg = a[Q30W-1] ^ b[Q30W-1];
    ua  = a[Q30W-1] ? Q30W'(-a) : Q30W'(a);
    ub  = b[Q30W-1] ? Q30W'(-b) : Q30W'(b);
    pr  = {{Q30W{1'b0}}, ua} * {{Q30W{1'b0}}, ub};
    pm  = pr[Q30W+29:30];
    return neg ? q30_t'(-pm) : q30_t'(pm);
  endfunction

  // Signed halving and quartering that truncate toward zero.
  function automatic q30_t half_tz(input q30_t v);
    q30_t t;
    t = v + q30_t'({{(Q30W-1){1'b0}}, v[Q30W-1]});
    return t >>> 1;
  endfunction

  function automatic q30_t quarter_tz(input q30_t v);
    q30_t t;
    t = v + (v[Q30W-1] ? q30_t'(3) : q30_t'(0));
    return t >>> 2;
  endfunction

  // Q30 to Q1.FRAC_BITS, round half away from zero, saturate at +-1.
  function automatic logic [OUT_W-1:0] to_out(input q30_t v);
    logic            neg;
    logic [Q30W-1:0] mag;
    logic [Q30W:0]   rs;
    logic [Q30W:0]   r;
    logic [Q30W:0]   res;
    neg = v[Q30W-1];
    mag = neg ? Q30W'(-v) : Q30W'(v);
    rs  = {1'b0, mag} + ((Q30W+1)'(1) << (OUT_SH - 1));
    r   = rs >> OUT_SH;
    if (r > ((Q30W+1)'(1) << FRAC_BITS)) begin
      r = (Q30W+1)'(1) << FRAC_BITS;
    end
    res = neg ? (Q30W+1)'(-r) : r;
    return res[OUT_W-1:0];
  endfunction

endpackage

FILE: sv/wrr_front.sv
module wrr_front import wrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ANG_IN_W-1:0]  in_angle_alpha,
  input  logic [ANG_IN_W-1:0]  in_angle_beta,
  input  logic [ANG_IN_W-1:0]  in_angle_gamma,
  input  logic [IDX_W-1:0]     in_row_index,
  input  logic [IDX_W-1:0]     in_col_index,
  input  q_stat_t              q_stat,
  output logic                 push,
  output item_t                push_item
);

  logic                        vld_r, vld_nxt;
  item_t                       item_r;
  logic                        load;
  logic [ANG_EXT_W-1:0]        a_ext, b_ext, g_ext;
  logic signed [ANGLE_BITS+4:0] pa, pg, e_full;
  logic                        m_bad, n_bad;

  assign busy = vld_r && q_stat.full;
  assign load = start && !busy;
  assign push = vld_r && !q_stat.full;
  assign push_item = item_r;

  assign a_ext = ANG_EXT_W'(in_angle_alpha);
  assign b_ext = ANG_EXT_W'(in_angle_beta);
  assign g_ext = ANG_EXT_W'(in_angle_gamma);

  // Phase of the exponential as a wrapping fraction of a turn.
  always_comb begin
    pa = $signed(in_row_index) * $signed({1'b0, a_ext[ANGLE_BITS-1:0]});
    pg = $signed(in_col_index) * $signed({1'b0, g_ext[ANGLE_BITS-1:0]});
    e_full = -pa - pg;
  end

  assign m_bad = !(in_row_index == IDX_M2 || in_row_index == IDX_M1 || in_row_index == IDX_Z ||
                   in_row_index == IDX_P1 || in_row_index == IDX_P2);
  assign n_bad = !(in_col_index == IDX_M2 || in_col_index == IDX_M1 || in_col_index == IDX_Z ||
                   in_col_index == IDX_P1 || in_col_index == IDX_P2);

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.beta    <= b_ext[ANGLE_BITS-1:0];
      item_r.phase   <= e_full[ANGLE_BITS-1:0];
      item_r.m       <= in_row_index;
      item_r.n       <= in_col_index;
      item_r.invalid <= m_bad || n_bad;
    end
  end

endmodule

FILE: sv/wrr_queue.sv
module wrr_queue import wrr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  output q_stat_t q_stat,
  output logic    pop,
  output item_t   pop_item
);

  item_t             mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  // The back takes an item in every cycle, so anything queued leaves at once.
  assign pop      = !q_stat.empty;
  assign pop_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

FILE: sv/wrr_trig.sv
module wrr_trig import wrr_pkg::*; (
  input  logic                  clk,
  input  logic [ANGLE_BITS-1:0] ang,
  output q30_t                  sin_o,
  output q30_t                  cos_o
);

  localparam int RB = ANGLE_BITS - 3;

  logic [29:0] t_a   [0:TERMS-1];
  logic [29:0] x_a   [0:TERMS-1];
  logic [2:0]  oct_a [0:TERMS-1];
  q30_t        s_a   [0:TERMS-1];
  q30_t        c_a   [0:TERMS-1];

  logic [2:0]     oct;
  logic [RB-1:0]  rem;
  logic [RB:0]    remm;
  logic [RB+30:0] xp;

  // Octant and the remainder, mirrored in odd octants, scaled by pi/4.
  always_comb begin
    oct  = ang[ANGLE_BITS-1 -: 3];
    rem  = ang[RB-1:0];
    remm = oct[0] ? (RB+1)'((RB+1)'(1) << RB) - {1'b0, rem} : {1'b0, rem};
    xp   = {30'b0, remm} * {{(RB+1){1'b0}}, PI4_Q30};
  end

  always_ff @(posedge clk) begin
    x_a[0]   <= xp[RB+29:RB];
    t_a[0]   <= xp[RB+29:RB];
    oct_a[0] <= oct;
    s_a[0]   <= '0;
    c_a[0]   <= ONE_Q30;
  end

  genvar j;
  generate
    for (j = 0; j < TERMS - 1; j++) begin : g_step
      localparam int K  = j + 2;
      localparam int KM = (K - 1) % 4;
      localparam longint unsigned RK = 64'h1_0000_0000 / K;

      logic [59:0] prod_r;
      logic [61:0] mr_r;
      logic [29:0] pb_r, xa_r, xb_r;
      logic [2:0]  oa_r, ob_r;
      q30_t        sa_r, ca_r, sb_r, cb_r;
      q30_t        tt, s_add, c_add;
      logic [29:0] pv, q0, tn;
      logic [33:0] qk, rm;

      // Fold the previous term into the sums while the next one is formed.
      always_comb begin
        tt    = q30_t'({4'b0, t_a[j]});
        s_add = s_a[j];
        c_add = c_a[j];
        case (KM)
          1:       s_add = s_a[j] + tt;
          2:       c_add = c_a[j] - tt;
          3:       s_add = s_a[j] - tt;
          default: c_add = c_a[j] + tt;
        endcase
      end

      always_ff @(posedge clk) begin
        prod_r <= {30'b0, t_a[j]} * {30'b0, x_a[j]};
        xa_r   <= x_a[j];
        oa_r   <= oct_a[j];
        sa_r   <= s_add;
        ca_r   <= c_add;
      end

      // Division by K as a reciprocal multiply.
      assign pv = prod_r[59:30];

      always_ff @(posedge clk) begin
        mr_r <= {32'b0, pv} * {30'b0, RK[31:0]};
        pb_r <= pv;
        xb_r <= xa_r;
        ob_r <= oa_r;
        sb_r <= sa_r;
        cb_r <= ca_r;
      end

      // The reciprocal estimate is at most one low; one compare fixes it.
      always_comb begin
        q0 = mr_r[61:32];
        qk = {4'b0, q0} * 34'(K);
        rm = {4'b0, pb_r} - qk;
        tn = (rm >= 34'(K)) ? q0 + 30'd1 : q0;
      end

      always_ff @(posedge clk) begin
        t_a[j+1]   <= tn;
        x_a[j+1]   <= xb_r;
        oct_a[j+1] <= ob_r;
        s_a[j+1]   <= sb_r;
        c_a[j+1]   <= cb_r;
      end
    end
  endgenerate

  q30_t       sf_r, cf_r;
  logic [2:0] of_r;

  // The last term is odd and belongs to the sine.
  always_ff @(posedge clk) begin
    sf_r <= s_a[TERMS-1] + q30_t'({4'b0, t_a[TERMS-1]});
    cf_r <= c_a[TERMS-1];
    of_r <= oct_a[TERMS-1];
  end

  always_ff @(posedge clk) begin
    case (of_r)
      3'd0: begin sin_o <= sf_r;  cos_o <= cf_r;  end
      3'd1: begin sin_o <= cf_r;  cos_o <= sf_r;  end
      3'd2: begin sin_o <= cf_r;  cos_o <= -sf_r; end
      3'd3: begin sin_o <= sf_r;  cos_o <= -cf_r; end
      3'd4: begin sin_o <= -sf_r; cos_o <= -cf_r; end
      3'd5: begin sin_o <= -cf_r; cos_o <= -sf_r; end
      3'd6: begin sin_o <= -cf_r; cos_o <= sf_r;  end
      default: begin sin_o <= -sf_r; cos_o <= cf_r; end
    endcase
  end

endmodule

FILE: sv/wrr_back.sv
module wrr_back import wrr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  item_t            in_item,
  output logic             out_vld,
  output logic [OUT_W-1:0] out_re,
  output logic [OUT_W-1:0] out_im,
  output logic             out_inv
);

  localparam int ML = TRIG_LAT + 4;

  typedef struct packed {
    logic [IDX_W-1:0] m;
    logic [IDX_W-1:0] n;
    logic             invalid;
  } meta_t;

  meta_t       meta_r [0:ML-1];
  logic [ML-1:0] vld_r;
  q30_t        sb, cb, se, ce;

  wrr_trig u_trig_beta  (.clk(clk), .ang(in_item.beta),  .sin_o(sb), .cos_o(cb));
  wrr_trig u_trig_phase (.clk(clk), .ang(in_item.phase), .sin_o(se), .cos_o(ce));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_vld <= 1'b0;
    end else begin
      vld_r   <= {vld_r[ML-2:0], in_vld};
      out_vld <= vld_r[ML-1];
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= '{m: in_item.m, n: in_item.n, invalid: in_item.invalid};
    for (int i = 1; i < ML; i++) begin
      meta_r[i] <= meta_r[i-1];
    end
  end

  // First products of the reduced term.
  q30_t p, q;
  q30_t c2_r, sc_r, ss_r, qsf_r, psf_r, qqf_r, ppf_r, p_r, q_r, se1_r, ce1_r;

  assign p = ONE_Q30 + cb;
  assign q = ONE_Q30 - cb;

  always_ff @(posedge clk) begin
    c2_r  <= mulq(cb, cb);
    sc_r  <= mulq(sb, cb);
    ss_r  <= mulq(sb, sb);
    qsf_r <= mulq(q, sb);
    psf_r <= mulq(p, sb);
    qqf_r <= mulq(q, q);
    ppf_r <= mulq(p, p);
    p_r   <= p;
    q_r   <= q;
    se1_r <= se;
    ce1_r <= ce;
  end

  q30_t qq_r, qs_r, kss_r, ps_r, pp_r, u_r, ks2_r, w_r, z0_r, se2_r, ce2_r;

  always_ff @(posedge clk) begin
    ks2_r <= mulq(SQ38_Q30, sc_r <<< 1);
    kss_r <= mulq(SQ38_Q30, ss_r);
    qs_r  <= half_tz(qsf_r);
    ps_r  <= half_tz(psf_r);
    qq_r  <= quarter_tz(qqf_r);
    pp_r  <= quarter_tz(ppf_r);
    u_r   <= half_tz(p_r) - c2_r;
    w_r   <= c2_r - half_tz(q_r);
    z0_r  <= half_tz((c2_r <<< 1) + c2_r - ONE_Q30);
    se2_r <= se1_r;
    ce2_r <= ce1_r;
  end

  // Pick the reduced element for (m, n) with its sign.
  meta_t mt2;
  q30_t  d;
  q30_t  d_r, se3_r, ce3_r;

  assign mt2 = meta_r[TRIG_LAT+1];

  always_comb begin
    d = '0;
    case (mt2.n)
      IDX_P2: begin
        case (mt2.m)
          IDX_M2:  d = qq_r;
          IDX_M1:  d = qs_r;
          IDX_Z:   d = kss_r;
          IDX_P1:  d = ps_r;
          default: d = pp_r;
        endcase
      end
      IDX_P1: begin
        case (mt2.m)
          IDX_M2:  d = qs_r;
          IDX_M1:  d = u_r;
          IDX_Z:   d = ks2_r;
          IDX_P1:  d = w_r;
          default: d = -ps_r;
        endcase
      end
      IDX_Z: begin
        case (mt2.m)
          IDX_M2:  d = kss_r;
          IDX_M1:  d = ks2_r;
          IDX_Z:   d = z0_r;
          IDX_P1:  d = -ks2_r;
          default: d = kss_r;
        endcase
      end
      IDX_M1: begin
        case (mt2.m)
          IDX_M2:  d = ps_r;
          IDX_M1:  d = w_r;
          IDX_Z:   d = -ks2_r;
          IDX_P1:  d = u_r;
          default: d = -qs_r;
        endcase
      end
      default: begin
        case (mt2.m)
          IDX_M2:  d = pp_r;
          IDX_M1:  d = -ps_r;
          IDX_Z:   d = kss_r;
          IDX_P1:  d = -qs_r;
          default: d = qq_r;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    d_r   <= d;
    se3_r <= se2_r;
    ce3_r <= ce2_r;
  end

  q30_t re4_r, im4_r;

  always_ff @(posedge clk) begin
    re4_r <= mulq(d_r, ce3_r);
    im4_r <= mulq(d_r, se3_r);
  end

  always_ff @(posedge clk) begin
    out_inv <= meta_r[ML-1].invalid;
    out_re  <= meta_r[ML-1].invalid ? '0 : to_out(re4_r);
    out_im  <= meta_r[ML-1].invalid ? '0 : to_out(im4_r);
  end

endmodule

FILE: sv/wigner_rotation_rank2_unit.sv
// Rank-2 Wigner rotation element D(m,n) = d(n,m;beta) * exp(-i(m*alpha + n*gamma)).
// Angles are unsigned fractions of a full turn; m and n are two's complement
// projection indices. An index outside -2..2 gives out_index_invalid high and a zero
// element. The element comes out as signed Q1.16, rounded half away from zero and
// saturated at plus or minus one. An item is taken at any rising edge with start high
// and busy low; busy stays low in normal use, so one item can be started in every
// cycle. Each result appears for exactly one cycle with out_valid high, in the order
// the items were taken. An item passes the front register, the queue, the sine and
// cosine pipelines (39 stages in all: a 13-term series, three stages per term for the
// multiply, the reciprocal multiply and the division correction), and then the
// reduced-term products, selection, phase product and output rounding. The receiver
// cannot hold results back, so none must be dropped by it.
module wigner_rotation_rank2_unit import wrr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ANG_IN_W-1:0] in_angle_alpha,
  input  logic [ANG_IN_W-1:0] in_angle_beta,
  input  logic [ANG_IN_W-1:0] in_angle_gamma,
  input  logic [IDX_W-1:0]    in_row_index,
  input  logic [IDX_W-1:0]    in_col_index,
  output logic                out_valid,
  output logic [OUT_W-1:0]    out_elem_real,
  output logic [OUT_W-1:0]    out_elem_imag,
  output logic                out_index_invalid
);

  q_stat_t q_stat;
  logic    push, pop;
  item_t   push_item, pop_item;

  // The front classifies the indices and forms the phase angle.
  wrr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_angle_alpha (in_angle_alpha),
    .in_angle_beta  (in_angle_beta),
    .in_angle_gamma (in_angle_gamma),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  wrr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  // The back is a fixed-latency pipeline that takes an item in every cycle.
  wrr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (pop),
    .in_item (pop_item),
    .out_vld (out_valid),
    .out_re  (out_elem_real),
    .out_im  (out_elem_imag),
    .out_inv (out_index_invalid)
  );

`ifndef SYNTHESIS
  // The back drains the queue every cycle, so the front never has to stall.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("front stalled on a full queue");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_invalid |-> out_elem_real == '0 && out_elem_imag == '0)
    else $error("invalid index gave a nonzero element");

  a_real_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_elem_real) <= $signed(OUT_W'(1) << FRAC_BITS) &&
                  $signed(out_elem_real) >= -$signed(OUT_W'(1) << FRAC_BITS))
    else $error("real part beyond saturation");

  a_imag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_elem_imag) <= $signed(OUT_W'(1) << FRAC_BITS) &&
                  $signed(out_elem_imag) >= -$signed(OUT_W'(1) << FRAC_BITS))
    else $error("imaginary part beyond saturation");
`endif

endmodule

FILE: sim/tb_wigner_rotation_rank2_unit.sv
`timescale 1ns / 1ps

module tb_wigner_rotation_rank2_unit;
  import wrr_pkg::*;

  // The block is stateless and has no configuration registers. Each item gives exactly
  // one element. The predictor below rebuilds the series trig, the reduced term table
  // and the output rounding at the block's widths.

  localparam int      MAX_CYCLES  = 400000;
  localparam int      LATENCY     = 45;
  localparam int      MAX_REPORTS = 10;
  localparam logic [63:0] ONE30   = 64'd1 << 30;
  localparam logic [63:0] PI4     = 64'd843314857;
  localparam logic signed [63:0] SQ38 = 64'sd657529896;

  typedef struct {
    logic [OUT_W-1:0] re;
    logic [OUT_W-1:0] im;
    logic             inv;
  } elem_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ANG_IN_W-1:0] in_angle_alpha = '0;
  logic [ANG_IN_W-1:0] in_angle_beta = '0;
  logic [ANG_IN_W-1:0] in_angle_gamma = '0;
  logic [IDX_W-1:0]    in_row_index = '0;
  logic [IDX_W-1:0]    in_col_index = '0;
  logic                out_valid;
  logic [OUT_W-1:0]    out_elem_real;
  logic [OUT_W-1:0]    out_elem_imag;
  logic                out_index_invalid;

  elem_t expected_elems[$];
  int    mismatches = 0;
  int    cycle_count = 0;
  int    idle_pct = 0;

  always #2 clk = ~clk;

  wigner_rotation_rank2_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_angle_alpha(in_angle_alpha), .in_angle_beta(in_angle_beta),
    .in_angle_gamma(in_angle_gamma), .in_row_index(in_row_index),
    .in_col_index(in_col_index), .out_valid(out_valid),
    .out_elem_real(out_elem_real), .out_elem_imag(out_elem_imag),
    .out_index_invalid(out_index_invalid)
  );

  // Sine and cosine of an angle given as a fraction of a turn, in Q30. The octant is
  // folded first, the remainder mirrored in odd octants, then a 13-term series is summed.
  function automatic void turn_sincos(input logic [31:0] ang,
                                      output logic signed [63:0] sn,
                                      output logic signed [63:0] cs);
    logic [31:0] t;
    logic [2:0]  oct;
    logic [63:0] r, x, term;
    logic signed [63:0] s, c;
    t = {ang[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    oct = t[31:29];
    r = {35'd0, t[28:0]};
    s = 0;
    c = ONE30;
    term = ONE30;
    if (oct[0]) r = (64'd1 << 29) - r;
    x = (r * PI4) >> 29;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * x) >> 30) / k;
      case (k % 4)
        1: s = s + term;
        2: c = c - term;
        3: s = s - term;
        default: c = c + term;
      endcase
    end
    case (oct)
      3'd0: begin sn = s;  cs = c;  end
      3'd1: begin sn = c;  cs = s;  end
      3'd2: begin sn = c;  cs = -s; end
      3'd3: begin sn = s;  cs = -c; end
      3'd4: begin sn = -s; cs = -c; end
      3'd5: begin sn = -c; cs = -s; end
      3'd6: begin sn = -c; cs = s;  end
      default: begin sn = -s; cs = c; end
    endcase
  endfunction

  // Q30 product that truncates toward zero.
  function automatic logic signed [63:0] q30_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [63:0] ua, ub, p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub) >> 30;
    return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [OUT_W-1:0] round_q1(input logic signed [63:0] v);
    logic [63:0] mag, r;
    mag = v < 0 ? -v : v;
    r = (mag + (64'd1 << (OUT_SH - 1))) >> OUT_SH;
    if (r > (64'd1 << FRAC_BITS)) r = 64'd1 << FRAC_BITS;
    if (v < 0) r = -r;
    return r[OUT_W-1:0];
  endfunction

  // Reduced rotation element d(n,m;beta); SystemVerilog division truncates toward zero.
  function automatic logic signed [63:0] reduced_term(input int m, input int n,
                                                      input logic signed [63:0] sb,
                                                      input logic signed [63:0] cb);
    logic signed [63:0] p, q, c2, ks2, kss, qs, ps, qq, pp, u, w, z;
    logic signed [63:0] row[5];
    p = $signed(ONE30) + cb;
    q = $signed(ONE30) - cb;
    c2 = q30_mul(cb, cb);
    ks2 = q30_mul(SQ38, 2 * q30_mul(sb, cb));
    kss = q30_mul(SQ38, q30_mul(sb, sb));
    qs = q30_mul(q, sb) / 2;
    ps = q30_mul(p, sb) / 2;
    qq = q30_mul(q, q) / 4;
    pp = q30_mul(p, p) / 4;
    u = p / 2 - c2;
    w = c2 - q / 2;
    z = (3 * c2 - $signed(ONE30)) / 2;
    case (n)
      2:  row = '{qq, qs, kss, ps, pp};
      1:  row = '{qs, u, ks2, w, -ps};
      0:  row = '{kss, ks2, z, -ks2, kss};
      -1: row = '{ps, w, -ks2, u, -qs};
      default: row = '{pp, -ps, kss, -qs, qq};
    endcase
    return row[m + 2];
  endfunction

  function automatic elem_t predict_element(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] g, input logic [2:0] mi,
                                            input logic [2:0] ni);
    elem_t e;
    int m, n;
    logic signed [63:0] sb, cb, se, ce, d;
    logic [31:0] ph;
    m = $signed(mi);
    n = $signed(ni);
    if (m < -2 || m > 2 || n < -2 || n > 2) begin
      e.re = '0;
      e.im = '0;
      e.inv = 1'b1;
      return e;
    end
    turn_sincos({16'd0, b}, sb, cb);
    // The phase -(m*alpha + n*gamma) wraps modulo a full turn.
    ph = 32'd0 - 32'(m) * {16'd0, a} - 32'(n) * {16'd0, g};
    turn_sincos(ph, se, ce);
    d = reduced_term(m, n, sb, cb);
    e.re = round_q1(q30_mul(d, ce));
    e.im = round_q1(q30_mul(d, se));
    e.inv = 1'b0;
    return e;
  endfunction

  // Offers one item, with a random idle gap first, and holds it until it is taken.
  task automatic send_item(input logic [15:0] a, input logic [15:0] b, input logic [15:0] g,
                           input logic [2:0] m, input logic [2:0] n);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_angle_alpha <= a;
    in_angle_beta <= b;
    in_angle_gamma <= g;
    in_row_index <= m;
    in_col_index <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_elems.push_back(predict_element(a, b, g, m, n));
  endtask

  // Lowers start after the last item of a phase so nothing extra is taken.
  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_elems.size() != 0) @(posedge clk);
  endtask

  // Every index pair, including the out-of-range codes, with the angle extremes.
  task automatic test_directed();
    logic [15:0] ext[4];
    ext = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000};
    for (int m = 0; m < 8; m++) begin
      for (int n = 0; n < 8; n++) begin
        send_item(ext[(m + n) % 4], ext[(m * 3 + n) % 4], ext[(n * 3 + m) % 4],
                  3'(m), 3'(n));
      end
    end
    // Exact octant boundaries of beta, where the mirroring meets zero.
    for (int k = 0; k < 8; k++) send_item(16'h1234, 16'(k * 16'h2000), 16'hABCD,
                                          IDX_P1, IDX_M2);
    stop_sending();
  endtask

  // Mostly valid index pairs; about one item in eight draws raw codes, which may be out of range.
  task automatic test_random(input int count, input int pct);
    logic [2:0] m, n;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) begin
        m = 3'($urandom);
        n = 3'($urandom);
      end else begin
        m = 3'($urandom_range(4) - 2);
        n = 3'($urandom_range(4) - 2);
      end
      send_item(16'($urandom), 16'($urandom), 16'($urandom), m, n);
    end
    stop_sending();
  endtask

  // The sender holds off until the pipeline is empty, then restarts.
  task automatic test_drain_pause();
    test_random(20, 0);
    wait_drained();
    test_random(20, 0);
  endtask

  // Each result is compared with the oldest expectation when the strobe is seen.
  always @(posedge clk) begin
    elem_t e;
    if (rst_n && out_valid) begin
      if (expected_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected element at cycle %0d", cycle_count);
      end else begin
        e = expected_elems.pop_front();
        if (e.re !== out_elem_real || e.im !== out_elem_imag ||
            e.inv !== out_index_invalid) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected re %h im %h inv %b, got re %h im %h inv %b",
                     e.re, e.im, e.inv, out_elem_real, out_elem_imag, out_index_invalid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(320, 0);
    test_random(320, 58);
    test_random(320, 25);
    test_drain_pause();
    test_random(280, 0);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_elems.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
